// ===== design/bf_dec_pkg.sv =====
// Shared types and constants for the Blowfish block decryptor.
// Used by bf_dec_feistel and blowfish_block_decrypt; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bf_dec_pkg;

	localparam int INDEX_W      = 11;
	localparam int WORD_W       = 32;
	localparam int TABLE_WORDS  = 1042;
	localparam int P_WORDS      = 18;
	localparam int P_IDX_W      = $clog2(P_WORDS);
	localparam int SBOX_COUNT   = 4;
	localparam int SBOX_ENTRIES = 256;
	localparam int SBOX_ADDR_W  = $clog2(SBOX_ENTRIES);
	localparam int BOX_SEL_W    = $clog2(SBOX_COUNT);

	localparam logic [INDEX_W-1:0] TABLE_END  = INDEX_W'(TABLE_WORDS);
	localparam logic [INDEX_W-1:0] P_END      = INDEX_W'(P_WORDS);
	localparam logic [INDEX_W-1:0] SBOX0_BASE = INDEX_W'(18);
	localparam logic [INDEX_W-1:0] SBOX1_BASE = INDEX_W'(274);
	localparam logic [INDEX_W-1:0] SBOX2_BASE = INDEX_W'(530);
	localparam logic [INDEX_W-1:0] SBOX3_BASE = INDEX_W'(786);

	localparam logic [P_IDX_W-1:0] ROUND_FIRST = P_IDX_W'(17);
	localparam logic [P_IDX_W-1:0] ROUND_LAST  = P_IDX_W'(2);

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MIX,
		ST_FINISH
	} state_t;

	// One write request into the S-box RAMs.
	typedef struct packed {
		logic                   en;
		logic [BOX_SEL_W-1:0]   box;
		logic [SBOX_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]      data;
	} sbox_wr_t;

endpackage

`default_nettype wire

// ===== design/bf_dec_feistel.sv =====
// Four S-box RAMs with registered reads and the Blowfish F function on their outputs.
// Depends on bf_dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bf_dec_feistel (
	input  logic                            clk,
	input  bf_dec_pkg::sbox_wr_t            wr,
	input  logic                            rd_en,
	input  logic [bf_dec_pkg::WORD_W-1:0]   z,
	output logic [bf_dec_pkg::WORD_W-1:0]   f
);
	import bf_dec_pkg::*;

	logic [WORD_W-1:0] rd_q [SBOX_COUNT];

	for (genvar b = 0; b < SBOX_COUNT; b++) begin : g_box
		logic [WORD_W-1:0] mem [SBOX_ENTRIES];

		// S-box b is indexed by byte b of z, counted from the most significant end.
		always_ff @(posedge clk) begin
			if (wr.en && (wr.box == BOX_SEL_W'(b))) begin
				mem[wr.addr] <= wr.data;
			end
			if (rd_en) begin
				rd_q[b] <= mem[z[WORD_W-1-SBOX_ADDR_W*b -: SBOX_ADDR_W]];
			end
		end
	end

	assign f = ((rd_q[0] + rd_q[1]) ^ rd_q[2]) + rd_q[3];

endmodule

`default_nettype wire

// ===== design/blowfish_block_decrypt.sv =====
// Top level of the Blowfish block decryptor: request handshakes, round-key registers,
// round sequencer and output register. Depends on bf_dec_pkg and bf_dec_feistel.
`timescale 1ns / 1ps
`default_nettype none

// A load request (op = 0) writes one key table word in the cycle it is accepted and
// gives no result; indexes 0..17 are the round keys, 18..1041 the four S-boxes, and
// higher indexes are dropped. A decrypt request (op = 1) occupies the block from the
// idle step in which it is accepted through 16 rounds, each a read step that reads
// the four S-box RAMs with the round's z and a mix step that folds their words
// through the shared F function and mixes the result into the halves, and a finish
// step that writes the output register. The synchronous S-box read is why each round
// needs a read step and a mix step. in_ready is low while a
// decrypt is in progress; a finished result may wait in the output register while
// further loads are taken, and a second decrypt waits at its last step until that
// result is taken. Every table entry a decrypt touches must have been loaded first.
module blowfish_block_decrypt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [bf_dec_pkg::INDEX_W-1:0]    table_index,
	input  logic [bf_dec_pkg::WORD_W-1:0]     table_word,
	input  logic [bf_dec_pkg::WORD_W-1:0]     block_word0,
	input  logic [bf_dec_pkg::WORD_W-1:0]     block_word1,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bf_dec_pkg::WORD_W-1:0]     plain_word0,
	output logic [bf_dec_pkg::WORD_W-1:0]     plain_word1
);
	import bf_dec_pkg::*;

	state_t               state_q, state_d;
	logic [P_IDX_W-1:0]   round_q;
	logic [WORD_W-1:0]    x_q, y_q, z_q;
	logic [WORD_W-1:0]    p_q [P_WORDS];
	logic [WORD_W-1:0]    plain0_q, plain1_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 is_load;
	logic                 start;
	logic                 rd_en;
	logic                 finish;
	logic [WORD_W-1:0]    z_d;
	logic [WORD_W-1:0]    f;
	logic [INDEX_W-1:0]   box_base;
	logic [INDEX_W-1:0]   box_off;
	sbox_wr_t             wr;

	assign accept  = in_valid && in_ready;
	assign is_load = (op == OP_LOAD);
	assign start   = accept && !is_load;
	assign z_d     = p_q[round_q] ^ x_q;

	// Route a load to one of the S-box RAMs.
	always_comb begin
		if (table_index >= SBOX3_BASE) begin
			wr.box   = BOX_SEL_W'(3);
			box_base = SBOX3_BASE;
		end else if (table_index >= SBOX2_BASE) begin
			wr.box   = BOX_SEL_W'(2);
			box_base = SBOX2_BASE;
		end else if (table_index >= SBOX1_BASE) begin
			wr.box   = BOX_SEL_W'(1);
			box_base = SBOX1_BASE;
		end else begin
			wr.box   = BOX_SEL_W'(0);
			box_base = SBOX0_BASE;
		end
		box_off = table_index - box_base;
		wr.addr = box_off[SBOX_ADDR_W-1:0];
		wr.data = table_word;
		wr.en   = accept && is_load && (table_index >= SBOX0_BASE)
			&& (table_index < TABLE_END);
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				state_d = (round_q == ROUND_LAST) ? ST_FINISH : ST_READ;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= ROUND_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				round_q <= ROUND_FIRST;
			end else if (state_q == ST_MIX) begin
				round_q <= round_q - P_IDX_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_load && (table_index < P_END)) begin
			p_q[table_index[P_IDX_W-1:0]] <= table_word;
		end
		if (start) begin
			x_q <= block_word1;
			y_q <= block_word0;
		end else if (state_q == ST_MIX) begin
			x_q <= f ^ y_q;
			y_q <= z_q;
		end
		if (rd_en) begin
			z_q <= z_d;
		end
		if (finish) begin
			plain0_q <= x_q ^ p_q[1];
			plain1_q <= y_q ^ p_q[0];
		end
	end

	bf_dec_feistel u_feistel (
		.clk   (clk),
		.wr    (wr),
		.rd_en (rd_en),
		.z     (z_d),
		.f     (f)
	);

	assign out_valid   = out_valid_q;
	assign plain_word0 = plain0_q;
	assign plain_word1 = plain1_q;

`ifndef SYNTHESIS
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("decryptor ready right after a decrypt request");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_MIX) |->
		(round_q >= ROUND_LAST && round_q <= ROUND_FIRST))
		else $error("round counter out of range during rounds");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
